@@ rtl/sppq_pkg.sv @@
// ----------------------------------------------------------------------------
// Strict priority queue package
// Shared constants, status codes and control types for the priority queue.
// ----------------------------------------------------------------------------
package sppq_pkg;

	// Default sizes for the top level parameters.
	localparam int MAX_LEVELS_DEF  = 8;
	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int DATA_WIDTH_DEF  = 32;

	// Fixed field widths of the stream payload.
	localparam int ITEM_W = 32;
	localparam int PRIO_W = 3;
	localparam int LVL_W  = 4;

	// Number of levels in use after reset.
	localparam logic [LVL_W-1:0] LEVELS_RESET = 4'd3;

	// Operation codes carried in the input side channel.
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_POP    = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_PRIO  = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;     // capture the input item
		logic exec;     // run the queue operation
		logic load_out; // move the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free; // output register can take a result this cycle
	} dp_stat_t;

endpackage

@@ rtl/sppq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module sppq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sppq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Strict priority queue controller
// Sequences one item through capture, execution and result hand-off.
// ----------------------------------------------------------------------------
module sppq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  sppq_pkg::dp_stat_t stat,
	output sppq_pkg::cmd_t     cmd
);

	import sppq_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.take     = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/sppq_dp.sv @@
// ----------------------------------------------------------------------------
// Strict priority queue datapath
// Per-level FIFO pointers and counts, the shared data memory, the level
// register and the output register.
// ----------------------------------------------------------------------------
module sppq_dp #(
	parameter int MAX_LEVELS  = sppq_pkg::MAX_LEVELS_DEF,
	parameter int LEVEL_DEPTH = sppq_pkg::LEVEL_DEPTH_DEF,
	parameter int DATA_WIDTH  = sppq_pkg::DATA_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sppq_pkg::cmd_t             cmd,
	output sppq_pkg::dp_stat_t         stat,
	input  logic                       in_mode,
	input  logic [sppq_pkg::ITEM_W-1:0] in_item,
	input  logic [sppq_pkg::PRIO_W-1:0] in_prio,
	input  logic                       cfg_we,
	input  logic [sppq_pkg::LVL_W-1:0]  cfg_levels,
	output logic                       m_valid,
	input  logic                       m_ready,
	output logic [sppq_pkg::ITEM_W-1:0] m_data,
	output logic                       m_data_valid,
	output logic [1:0]                 m_status,
	output logic                       m_empty
);

	import sppq_pkg::*;

	localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int PW    = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CW    = $clog2(LEVEL_DEPTH + 1);
	localparam int DEPTH = MAX_LEVELS * LEVEL_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	// Captured item.
	logic                  mode_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [PRIO_W-1:0]     prio_q;

	// Per-level FIFO state.
	logic [PW-1:0] head_q  [MAX_LEVELS];
	logic [PW-1:0] tail_q  [MAX_LEVELS];
	logic [CW-1:0] count_q [MAX_LEVELS];

	logic [LVL_W-1:0] levels_q;
	status_t          res_status_q;
	logic             res_valid_q;

	// Output register.
	logic              m_valid_q;
	logic [ITEM_W-1:0] m_data_q;
	logic              m_data_valid_q;
	status_t           m_status_q;
	logic              m_empty_q;

	logic [LVL_W:0]        n_eff;
	logic [MAX_LEVELS-1:0] nonempty;
	logic                  any_item;
	logic [LW-1:0]         pop_lvl;
	logic [LW-1:0]         ins_lvl;
	logic                  prio_ok;
	logic                  lvl_full;
	logic                  ins_go;
	logic                  pop_go;
	logic [AW-1:0]         waddr;
	logic [AW-1:0]         raddr;
	logic [DATA_WIDTH-1:0] rdata;
	logic [PW-1:0]         tail_next;
	logic [PW-1:0]         head_next;

	// Effective level count, clamped to the levels that exist.
	always_comb begin
		if ({1'b0, levels_q} > (LVL_W+1)'(MAX_LEVELS)) begin
			n_eff = (LVL_W+1)'(MAX_LEVELS);
		end else begin
			n_eff = {1'b0, levels_q};
		end
	end

	// Non-empty flags of the levels in use.
	always_comb begin
		for (int i = 0; i < MAX_LEVELS; i++) begin
			nonempty[i] = ((LVL_W+1)'(i) < n_eff) && (count_q[i] != '0);
		end
	end

	assign any_item = |nonempty;

	// Priority encoder: the lowest-numbered non-empty level wins.
	always_comb begin
		pop_lvl = '0;
		for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
			if (nonempty[i]) begin
				pop_lvl = LW'(i);
			end
		end
	end

	// Insert checks: bad priority takes precedence over a full level.
	assign ins_lvl  = LW'(prio_q);
	assign prio_ok  = (LVL_W+1)'(prio_q) < n_eff;
	assign lvl_full = prio_ok && (count_q[ins_lvl] == CW'(LEVEL_DEPTH));
	assign ins_go   = cmd.exec && (mode_q == MODE_INSERT) && prio_ok && !lvl_full;
	assign pop_go   = cmd.exec && (mode_q == MODE_POP) && any_item;

	// Pointer advance with wrap at the level depth.
	assign tail_next = (tail_q[ins_lvl] == PW'(LEVEL_DEPTH - 1)) ? '0 : tail_q[ins_lvl] + 1'b1;
	assign head_next = (head_q[pop_lvl] == PW'(LEVEL_DEPTH - 1)) ? '0 : head_q[pop_lvl] + 1'b1;

	// Memory addresses: level base plus position inside the level.
	assign waddr = AW'(ins_lvl) * AW'(LEVEL_DEPTH) + AW'(tail_q[ins_lvl]);
	assign raddr = AW'(pop_lvl) * AW'(LEVEL_DEPTH) + AW'(head_q[pop_lvl]);

	sppq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ins_go),
		.waddr(waddr),
		.wdata(data_q),
		.re   (pop_go),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= in_mode;
			data_q <= DATA_WIDTH'(in_item);
			prio_q <= in_prio;
		end
	end

	// Level register, pointers, counts and the pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q     <= LEVELS_RESET;
			res_status_q <= ST_OK;
			res_valid_q  <= 1'b0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				levels_q <= cfg_levels;
			end
			if (ins_go) begin
				tail_q[ins_lvl]  <= tail_next;
				count_q[ins_lvl] <= count_q[ins_lvl] + 1'b1;
			end
			if (pop_go) begin
				head_q[pop_lvl]  <= head_next;
				count_q[pop_lvl] <= count_q[pop_lvl] - 1'b1;
			end
			if (cmd.exec) begin
				res_valid_q <= pop_go;
				if (mode_q == MODE_POP) begin
					res_status_q <= any_item ? ST_OK : ST_POP_EMPTY;
				end else if (!prio_ok) begin
					res_status_q <= ST_BAD_PRIO;
				end else if (lvl_full) begin
					res_status_q <= ST_FULL;
				end else begin
					res_status_q <= ST_OK;
				end
			end
		end
	end

	// Output register valid: set on load, cleared when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output payload; the emptiness flag reflects the counts after the step.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_data_q       <= res_valid_q ? ITEM_W'(rdata) : '0;
			m_data_valid_q <= res_valid_q;
			m_status_q     <= res_status_q;
			m_empty_q      <= !any_item;
		end
	end

	assign stat.out_free = !m_valid_q || m_ready;
	assign m_valid       = m_valid_q;
	assign m_data        = m_data_q;
	assign m_data_valid  = m_data_valid_q;
	assign m_status      = m_status_q;
	assign m_empty       = m_empty_q;

endmodule

@@ rtl/strict_priority_multi_queue.sv @@
// ----------------------------------------------------------------------------
// Strict priority multi-queue
// One FIFO per priority level in a shared memory; inserts push onto the
// FIFO of their level, pops take the head of the highest-priority level.
//
//   Channel  Direction  Handshake            Payload
//   s_axis   in         s_tvalid/s_tready    tuser: mode; tdata: item, prio
//   m_axis   out        m_tvalid/m_tready    tuser: out_valid; tdata: result
//   cfg      in         cfg_valid/cfg_ready  cfg_data: levels_in_use
//
// Each item passes through capture, execution with one memory access,
// and the load of the output register.
// A new item is accepted while an earlier result waits in the output register.
// A stalled output holds the block in its final step until the result leaves.
// Reset empties every level and sets the levels in use to three.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue #(
	parameter int MAX_LEVELS  = sppq_pkg::MAX_LEVELS_DEF,
	parameter int LEVEL_DEPTH = sppq_pkg::LEVEL_DEPTH_DEF,
	parameter int DATA_WIDTH  = sppq_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] item_data, [34:32] priority_req, zero pad
	input  logic [0:0]  s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] out_data, [33:32] status, [34] now_empty
	output logic [0:0]  m_tuser,   // [0] out_valid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data   // levels_in_use
);

	import sppq_pkg::*;

	cmd_t              cmd;
	dp_stat_t          stat;
	logic [ITEM_W-1:0] res_data;
	logic              res_valid;
	logic [1:0]        res_status;
	logic              res_empty;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	sppq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	sppq_dp #(
		.MAX_LEVELS (MAX_LEVELS),
		.LEVEL_DEPTH(LEVEL_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_mode     (s_tuser[0]),
		.in_item     (s_tdata[31:0]),
		.in_prio     (s_tdata[34:32]),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_levels  (cfg_data),
		.m_valid     (m_tvalid),
		.m_ready     (m_tready),
		.m_data      (res_data),
		.m_data_valid(res_valid),
		.m_status    (res_status),
		.m_empty     (res_empty)
	);

	// Result packing.
	assign m_tdata = {5'b0, res_empty, res_status, res_data};
	assign m_tuser = res_valid;

endmodule
